// ===== src/lrs_pkg.sv =====
// Shared types, constants and the Life neighborhood function for the row stream stepper.
`default_nettype none
package lrs_pkg;

    localparam int unsigned ROW_W       = 64;
    localparam int unsigned COLS_W      = 7;
    localparam int unsigned MAX_COLUMNS = 64;
    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(64);

    // one board row as it arrives
    typedef struct packed {
        logic [ROW_W-1:0] row_cells;
        logic             final_row;
    } row_item_t;

    // one next-generation row
    typedef struct packed {
        logic [ROW_W-1:0] next_row_cells;
        logic             frame_done;
    } result_item_t;

    // classified item handed from front to back
    typedef struct packed {
        logic [ROW_W-1:0] above;
        logic [ROW_W-1:0] middle;
        logic [ROW_W-1:0] below;
        logic             has_mid;
        logic             last;
    } job_t;

    // B3/S23 on three rows, all columns side by side
    function automatic logic [ROW_W-1:0] evolve(
        input logic [ROW_W-1:0] up,
        input logic [ROW_W-1:0] mid,
        input logic [ROW_W-1:0] down,
        input logic [ROW_W-1:0] mask
    );
        logic [ROW_W-1:0] u;
        logic [ROW_W-1:0] m;
        logic [ROW_W-1:0] d;
        logic [ROW_W-1:0] ul;
        logic [ROW_W-1:0] ur;
        logic [ROW_W-1:0] ml;
        logic [ROW_W-1:0] mr;
        logic [ROW_W-1:0] dl;
        logic [ROW_W-1:0] dr;
        logic [ROW_W-1:0] res;
        logic [3:0]       cnt;
        u  = up & mask;
        m  = mid & mask;
        d  = down & mask;
        // left neighbor of column x is bit x-1, right neighbor is bit x+1
        ul = u << 1;
        ur = u >> 1;
        ml = m << 1;
        mr = m >> 1;
        dl = d << 1;
        dr = d >> 1;
        for (int x = 0; x < int'(ROW_W); x++)
        begin
            cnt = 4'(ul[x]) + 4'(u[x]) + 4'(ur[x]) + 4'(ml[x]) + 4'(mr[x])
                + 4'(dl[x]) + 4'(d[x]) + 4'(dr[x]);
            res[x] = (cnt == 4'd3) || (m[x] && (cnt == 4'd2));
        end
        return res & mask;
    endfunction

endpackage
`default_nettype wire

// ===== src/life_row_stream_step.sv =====
// Top level of the streaming Life row stepper: config register, front, job queue, back.
`default_nettype none
// Computes one B3/S23 Life generation for a board streamed one row per item, top row
// first, column x in bit x. Each row item yields the next-generation row of the row
// before it, so results trail the input by one row; the bottom row (final_row set) also
// yields the last new row with frame_done set and clears the row store. A row item is
// taken every cycle while the job queue is not full; a bottom row that closes a held row
// yields two result rows in turn, since the single neighborhood unit in the back part makes
// one row per cycle while the output queue has space. The width written through cfg_data
// masks input and output rows; write it only while the block is idle.
module life_row_stream_step
#(
    parameter int unsigned MAX_COLUMNS = lrs_pkg::MAX_COLUMNS
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            push,
    output logic                                 full,
    input  wire lrs_pkg::row_item_t              row_item,
    output logic                                 empty,
    input  wire logic                            pop,
    output lrs_pkg::result_item_t                result_item,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lrs_pkg::COLS_W-1:0]      cfg_data
);

    logic [lrs_pkg::COLS_W-1:0] cols_reg;
    logic [lrs_pkg::COLS_W-1:0] cols_eff;
    logic [lrs_pkg::ROW_W-1:0]  mask;
    logic                       accept;
    lrs_pkg::job_t              new_job;
    lrs_pkg::job_t              head_job;
    logic                       q_empty;
    logic                       job_pop;

    assign cfg_ready = 1'b1;
    assign accept    = push && !full;

    // width register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= lrs_pkg::COLS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            cols_reg <= cfg_data;
        end
    end

    // board width mask
    always_comb
    begin
        cols_eff = (cols_reg > lrs_pkg::COLS_W'(MAX_COLUMNS))
                 ? lrs_pkg::COLS_W'(MAX_COLUMNS) : cols_reg;
        if (cols_eff >= lrs_pkg::COLS_W'(lrs_pkg::ROW_W))
        begin
            mask = '1;
        end
        else
        begin
            mask = (lrs_pkg::ROW_W'(1) << cols_eff) - lrs_pkg::ROW_W'(1);
        end
    end

    lrs_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .mask     (mask),
        .row_item (row_item),
        .accept   (accept),
        .job      (new_job)
    );

    lrs_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (new_job),
        .full     (full),
        .pop      (job_pop),
        .empty    (q_empty),
        .head_job (head_job)
    );

    lrs_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .mask        (mask),
        .job_valid   (!q_empty),
        .job         (head_job),
        .job_pop     (job_pop),
        .empty       (empty),
        .pop         (pop),
        .result_item (result_item)
    );

endmodule
`default_nettype wire

// ===== src/lrs_queue.sv =====
// Two-entry job queue between the front and back parts.
`default_nettype none
module lrs_queue
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire lrs_pkg::job_t push_job,
    output logic              full,
    input  wire logic         pop,
    output logic              empty,
    output lrs_pkg::job_t     head_job
);

    lrs_pkg::job_t slot_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    cnt_reg;
    logic          do_push;
    logic          do_pop;

    assign full     = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign head_job = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // payload slots
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg <= cnt_reg + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule
`default_nettype wire

// ===== src/lrs_front.sv =====
// Front part: takes rows, keeps the two previous rows and issues one job per item.
`default_nettype none
module lrs_front
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lrs_pkg::ROW_W-1:0]  mask,
    input  wire lrs_pkg::row_item_t         row_item,
    input  wire logic                       accept,
    output lrs_pkg::job_t                   job
);

    logic [lrs_pkg::ROW_W-1:0] above_reg;
    logic [lrs_pkg::ROW_W-1:0] middle_reg;
    logic                      mid_valid_reg;
    logic [lrs_pkg::ROW_W-1:0] row_m;

    assign row_m = row_item.row_cells & mask;

    // job carries the held rows plus the new one
    always_comb
    begin
        job.above   = above_reg;
        job.middle  = middle_reg;
        job.below   = row_m;
        job.has_mid = mid_valid_reg;
        job.last    = row_item.final_row;
    end

    // row store: shift on each item, clear after the bottom row
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            above_reg     <= '0;
            middle_reg    <= '0;
            mid_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (row_item.final_row)
            begin
                above_reg     <= '0;
                middle_reg    <= '0;
                mid_valid_reg <= 1'b0;
            end
            else
            begin
                above_reg     <= mid_valid_reg ? middle_reg : '0;
                middle_reg    <= row_m;
                mid_valid_reg <= 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/lrs_back.sv =====
// Back part: expands jobs into result rows and holds them in a small output queue.
`default_nettype none
module lrs_back
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [lrs_pkg::ROW_W-1:0]  mask,
    input  wire logic                       job_valid,
    input  wire lrs_pkg::job_t              job,
    output logic                            job_pop,
    output logic                            empty,
    input  wire logic                       pop,
    output lrs_pkg::result_item_t           result_item
);

    lrs_pkg::result_item_t     out_reg [2];
    logic                      wr_ptr_reg;
    logic                      rd_ptr_reg;
    logic [1:0]                cnt_reg;
    logic                      phase_reg;
    logic                      phase_next;
    logic                      produce;
    logic                      space;
    logic                      is_first;
    logic                      do_write;
    logic                      do_read;
    logic [lrs_pkg::ROW_W-1:0] up;
    logic [lrs_pkg::ROW_W-1:0] mid;
    logic [lrs_pkg::ROW_W-1:0] down;
    lrs_pkg::result_item_t     res;

    assign space   = (cnt_reg != 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_read = pop && !empty;
    assign result_item = out_reg[rd_ptr_reg];

    // pick which row of the job is produced this cycle
    always_comb
    begin
        is_first = job.has_mid && !phase_reg;
        produce  = job_valid && (is_first || job.last);
        if (is_first)
        begin
            up   = job.above;
            mid  = job.middle;
            down = job.below;
        end
        else
        begin
            up   = job.has_mid ? job.middle : '0;
            mid  = job.below;
            down = '0;
        end
        res.next_row_cells = lrs_pkg::evolve(up, mid, down, mask);
        res.frame_done     = !is_first;
        do_write   = produce && space;
        phase_next = phase_reg;
        job_pop    = 1'b0;
        if (job_valid && !produce)
        begin
            job_pop = 1'b1;
        end
        else if (do_write)
        begin
            if (is_first && job.last)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                job_pop    = 1'b1;
            end
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            out_reg[wr_ptr_reg] <= res;
        end
    end

    // output queue control and job phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            phase_reg  <= 1'b0;
        end
        else
        begin
            if (do_write)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_read)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            cnt_reg   <= cnt_reg + 2'(do_write) - 2'(do_read);
            phase_reg <= phase_next;
        end
    end

    // second phase only exists for a bottom row that also closes a held row
    a_phase_job: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (job_valid && job.has_mid && job.last))
        else $error("second phase without a matching job");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output queue count out of range");

    a_phase_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && space) |=> !phase_reg)
        else $error("second phase did not finish");

    a_no_pop_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && produce && !space) |-> !job_pop)
        else $error("job dropped while output queue full");

endmodule
`default_nettype wire
